### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset
`define ILIST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset
`define ILIST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ilist_pkg.sv
package ilist_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_GET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_POP    = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_op_t;

endpackage

### design/ilist_cell.sv
module ilist_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 6,
  parameter int IDX       = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  ilist_pkg::cell_op_t     op,
  input  logic [IDX_W-1:0]        idx,
  input  logic [WORD_BITS-1:0]    wr_word,
  input  logic [WORD_BITS-1:0]    prev_word,
  input  logic [WORD_BITS-1:0]    next_word,
  output logic [WORD_BITS-1:0]    q,
  output logic [WORD_BITS-1:0]    tap
);
  import ilist_pkg::*;

  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic [WORD_BITS-1:0] tap_r, tap_nxt;
  logic                 is_match;
  logic                 is_above;

  assign is_match = (idx == IDX_W'(IDX));
  assign is_above = (idx < IDX_W'(IDX));

  always_comb begin
    data_nxt = data_r;
    if (op.load && is_match) begin
      data_nxt = wr_word;
    end else if (op.shift_up && is_above) begin
      data_nxt = prev_word;
    end else if (op.shift_down && (is_above || is_match)) begin
      data_nxt = next_word;
    end
    tap_nxt = is_match ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      tap_r  <= tap_nxt;
    end
  end

  assign q   = data_r;
  assign tap = tap_r;

endmodule

### design/indexed_list_engine_core.sv
// Ordered list of up to CAPACITY words held in a row of cells, with push, get,
// insert, pop and remove at an index. Each transaction is accepted and checked
// against the count in S_IDLE; in S_EXEC every cell loads or shifts from its
// neighbour in parallel while the addressed cell latches its old word; in S_DONE
// the cell taps are ORed into the result register. S_DONE is held while an earlier
// result still waits unaccepted in the output register. Insert and remove cost
// no more than push or get. A new transaction is taken as soon as the block is
// idle, even while the previous result still waits on the output. No clearing
// pass is needed after reset; only entries below the count are ever read.
module indexed_list_engine_core #(
  parameter int CAPACITY  = ilist_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = ilist_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_word_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_word_out,
  output logic [1:0]         out_status,
  output logic [6:0]         out_count
);
  import ilist_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  cell_op_t             op_r, op_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [WORD_BITS-1:0] wr_word_r;
  status_t              status_r, status_nxt;
  logic                 sentinel_r, sentinel_nxt;
  logic                 use_tap_r, use_tap_nxt;
  logic                 inc_r, inc_nxt;
  logic                 dec_r, dec_nxt;

  logic                 out_valid_r;
  logic signed [31:0]   out_word_r;
  status_t              out_status_r;
  logic [6:0]           out_count_r;

  logic                 accept;
  logic                 cell_en;
  logic                 load_out;
  logic                 full;
  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;

  logic [WORD_BITS-1:0] cell_q   [CAPACITY];
  logic [WORD_BITS-1:0] cell_tap [CAPACITY];
  logic signed [WORD_BITS-1:0] tap_or;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    cell_en  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: cell_en = 1'b1;
      S_DONE: load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign full    = (count_r == CW'(CAPACITY));
  assign pos_ext = CMPW'(in_position);
  assign cnt_ext = CMPW'(count_r);

  // decode and range checks
  always_comb begin
    op_nxt       = '0;
    idx_nxt      = AW'(in_position);
    status_nxt   = STAT_OK;
    sentinel_nxt = 1'b0;
    use_tap_nxt  = 1'b0;
    inc_nxt      = 1'b0;
    dec_nxt      = 1'b0;
    case (cmd_t'(in_cmd))
      CMD_PUSH: begin
        idx_nxt = AW'(count_r);
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          op_nxt.load = 1'b1;
          inc_nxt     = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos_ext >= cnt_ext) status_nxt = STAT_BAD;
        else use_tap_nxt = 1'b1;
      end
      CMD_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = STAT_BAD;
        end else begin
          op_nxt.load     = 1'b1;
          op_nxt.shift_up = 1'b1;
          inc_nxt         = 1'b1;
        end
      end
      CMD_POP: begin
        idx_nxt = AW'(count_r - CW'(1));
        if (count_r == '0) begin
          status_nxt   = STAT_BAD;
          sentinel_nxt = 1'b1;
        end else begin
          use_tap_nxt = 1'b1;
          dec_nxt     = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt   = STAT_BAD;
          sentinel_nxt = 1'b1;
        end else begin
          op_nxt.shift_down = 1'b1;
          use_tap_nxt       = 1'b1;
          dec_nxt           = 1'b1;
        end
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cell_en && inc_r) count_nxt = count_r + CW'(1);
    else if (cell_en && dec_r) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_nxt;
      idx_r      <= idx_nxt;
      wr_word_r  <= WORD_BITS'(in_word_in);
      status_r   <= status_nxt;
      sentinel_r <= sentinel_nxt;
      use_tap_r  <= use_tap_nxt;
      inc_r      <= inc_nxt;
      dec_r      <= dec_nxt;
    end
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] prev_w;
      logic [WORD_BITS-1:0] next_w;
      if (i == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_lo
        assign prev_w = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign next_w = cell_q[i];
      end else begin : g_mid_hi
        assign next_w = cell_q[i+1];
      end
      ilist_cell #(
        .WORD_BITS(WORD_BITS),
        .IDX_W    (AW),
        .IDX      (i)
      ) u_cell (
        .clk      (clk),
        .en       (cell_en),
        .op       (op_r),
        .idx      (idx_r),
        .wr_word  (wr_word_r),
        .prev_word(prev_w),
        .next_word(next_w),
        .q        (cell_q[i]),
        .tap      (cell_tap[i])
      );
    end
  endgenerate

  // only the addressed cell's tap is non-zero
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (use_tap_r) out_word_r <= 32'(tap_or);
      else if (sentinel_r) out_word_r <= '1;
      else out_word_r <= '0;
      out_status_r <= status_r;
      out_count_r  <= 7'(count_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

endmodule

### design/ilist_checker.sv
`include "assert_macros.svh"

module ilist_checker #(
  parameter int CAPACITY = ilist_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_word_out,
  input logic [1:0]         out_status,
  input logic [6:0]         out_count
);
  import ilist_pkg::*;

  localparam int CNT_CAP = (CAPACITY > 127) ? 127 : CAPACITY;

  logic st_known;
  logic full_ok;
  logic bad_ok;

  assign st_known = out_status inside {STAT_OK, STAT_BAD, STAT_FULL};
  assign full_ok  = (out_word_out == '0) &&
                    (CAPACITY > 127 || 32'(out_count) == 32'(CNT_CAP));
  assign bad_ok   = (out_word_out == '0) || (out_word_out == '1);

  `ILIST_ASSERT_IMP(a_status_code, out_valid, st_known, "undefined status code")

  `ILIST_ASSERT_IMP(a_full_count, out_valid && out_status == STAT_FULL, full_ok, "bad full result")

  `ILIST_ASSERT_IMP(a_bad_word, out_valid && out_status == STAT_BAD, bad_ok, "bad index word")

  `ILIST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word_out) && $stable(out_count), "stalled result changed")

endmodule

bind indexed_list_engine_core ilist_checker #(.CAPACITY(CAPACITY)) u_ilist_checker (.*);

### tb/tb_indexed_list_engine_core.sv
module tb_indexed_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ilist_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int OPS_WANTED = 1100;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
  localparam logic signed [31:0] WORD_NONE = -32'sd1;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] pos;
    logic [31:0] word;
    logic hold;
  } list_op_t;

  typedef struct packed {
    logic signed [31:0] word;
    status_t status;
    logic [6:0] count;
  } list_reply_t;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_NOISE
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [6:0] in_position = '0;
  logic signed [31:0] in_word_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_word_out;
  logic [1:0] out_status;
  logic [6:0] out_count;

  list_op_t ops_to_send[$];
  list_reply_t list_replies_due[$];
  list_op_t next_op;
  list_reply_t want;
  list_reply_t got;

  logic signed [31:0] shadow_words[CAPACITY];
  int shadow_len = 0;

  int gen_count = 0;
  int ops_planned = 0;
  int ops_accepted = 0;
  bit hold_next = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int errors = 0;
  int cycle_count = 0;

  indexed_list_engine_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_position(in_position),
    .in_word_in(in_word_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word_out(out_word_out),
    .out_status(out_status),
    .out_count(out_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic list_reply_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                logic signed [31:0] word);
    list_reply_t r;
    r.word = '0;
    r.status = STAT_OK;
    case (op)
      CMD_PUSH: begin
        if (shadow_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_words[shadow_len] = word;
          shadow_len++;
        end
      end
      CMD_GET: begin
        if (pos >= shadow_len) r.status = STAT_BAD;
        else r.word = shadow_words[pos];
      end
      CMD_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (pos > shadow_len) begin
          r.status = STAT_BAD;
        end else begin
          for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[pos] = word;
          shadow_len++;
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) begin
          r.status = STAT_BAD;
          r.word = WORD_NONE;
        end else begin
          shadow_len--;
          r.word = shadow_words[shadow_len];
        end
      end
      CMD_REMOVE: begin
        if (pos >= shadow_len) begin
          r.status = STAT_BAD;
          r.word = WORD_NONE;
        end else begin
          r.word = shadow_words[pos];
          for (int i = pos + 1; i < shadow_len; i++) shadow_words[i - 1] = shadow_words[i];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.count = shadow_len[6:0];
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 19))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return WORD_NONE;
      default: return $urandom;
    endcase
  endfunction

  // tracks only the count, to steer positions towards valid indices
  task automatic add_op(logic [2:0] op, int pos, logic [31:0] word);
    list_op_t o;
    o.op = op;
    o.pos = pos[6:0];
    o.word = word;
    o.hold = hold_next;
    hold_next = 1'b0;
    ops_to_send.push_back(o);
    ops_planned++;
    case (op)
      CMD_PUSH: if (gen_count < CAPACITY) gen_count++;
      CMD_INSERT: if (gen_count < CAPACITY && o.pos <= gen_count) gen_count++;
      CMD_POP: if (gen_count > 0) gen_count--;
      CMD_REMOVE: if (o.pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic int valid_index();
    return (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
  endfunction

  task automatic add_mixed_op();
    logic [2:0] op;
    int pos;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    else op = 3'($urandom_range(CMD_PUSH, CMD_REMOVE));
    if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 127);
    else if (op == CMD_INSERT) pos = $urandom_range(0, gen_count);
    else if (op == CMD_GET || op == CMD_REMOVE) pos = valid_index();
    else pos = $urandom_range(0, 127);
    add_op(op, pos, rand_word());
  endtask

  task automatic plan_ops();
    phase_t ph;
    int n;
    add_op(CMD_POP, 0, '0);
    add_op(CMD_REMOVE, 0, '0);
    add_op(CMD_GET, 0, '0);
    add_op(CMD_INSERT, 1, 32'h1111_1111);
    add_op(CMD_INSERT, 0, WORD_MAX);
    add_op(CMD_PUSH, 127, WORD_MIN);
    add_op(CMD_PUSH, 0, WORD_NONE);
    add_op(CMD_INSERT, 0, '0);
    add_op(CMD_INSERT, 4, 32'h1234_5678);
    add_op(CMD_INSERT, 2, 32'ha5a5_a5a5);
    add_op(CMD_GET, 0, WORD_NONE);
    add_op(CMD_GET, 5, '0);
    add_op(CMD_GET, 6, '0);
    add_op(CMD_GET, 127, '0);
    add_op(CMD_REMOVE, 127, '0);
    add_op(CMD_REMOVE, 2, '0);
    add_op(CMD_REMOVE, 0, '0);
    add_op(CMD_REMOVE, 3, '0);
    add_op(CMD_UNUSED_FIRST, 127, WORD_NONE);
    add_op(3'd6, 42, WORD_MAX);
    add_op(CMD_UNUSED_LAST, 85, WORD_MIN);
    add_op(CMD_INSERT, 127, WORD_NONE);
    add_op(CMD_POP, 127, WORD_NONE);
    hold_next = 1'b1;
    while (ops_planned < OPS_WANTED) begin
      n = $urandom_range(0, 9);
      if (n < 2) ph = PH_FILL;
      else if (n < 4) ph = PH_DRAIN;
      else if (n < 9) ph = PH_MIXED;
      else ph = PH_NOISE;
      if ($urandom_range(0, 2) == 0) hold_next = 1'b1;
      case (ph)
        PH_FILL: begin
          while (gen_count < CAPACITY) begin
            n = $urandom_range(0, 9);
            if (n < 5) add_op(CMD_PUSH, $urandom_range(0, 127), rand_word());
            else if (n < 9) add_op(CMD_INSERT, $urandom_range(0, gen_count), rand_word());
            else add_op(CMD_GET, valid_index(), rand_word());
          end
          add_op(CMD_GET, CAPACITY - 1, rand_word());
          add_op(CMD_GET, CAPACITY, rand_word());
          repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 1)) add_op(CMD_PUSH, $urandom_range(0, 127), rand_word());
            else add_op(CMD_INSERT, $urandom_range(0, 127), rand_word());
          end
        end
        PH_DRAIN: begin
          while (gen_count > 0) begin
            n = $urandom_range(0, 9);
            if (n < 4) add_op(CMD_POP, $urandom_range(0, 127), rand_word());
            else if (n < 9) add_op(CMD_REMOVE, valid_index(), rand_word());
            else add_op(CMD_GET, valid_index(), rand_word());
          end
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1)) add_op(CMD_POP, $urandom_range(0, 127), rand_word());
            else add_op(CMD_REMOVE, $urandom_range(0, 127), rand_word());
          end
        end
        PH_MIXED: begin
          repeat ($urandom_range(20, 80)) add_mixed_op();
        end
        default: begin
          repeat ($urandom_range(10, 30))
            add_op(3'($urandom_range(0, 7)), $urandom_range(0, 127), rand_word());
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        list_replies_due.push_back(apply_list_op(in_cmd, in_position, in_word_in));
        ops_accepted++;
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() > 0 &&
                   !(ops_to_send[0].hold && list_replies_due.size() > 0)) begin
        next_op = ops_to_send.pop_front();
        in_valid <= 1'b1;
        in_cmd <= next_op.op;
        in_position <= next_op.pos;
        in_word_in <= next_op.word;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 70);
        send_gap = (send_calm > 0) ? 0 : draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_word_out, out_status, out_count};
        if (list_replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got word %0d status %0d count %0d",
                   $time, out_word_out, out_status, out_count);
          errors++;
        end else begin
          want = list_replies_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected word %0d st %0d cnt %0d, got word %0d st %0d cnt %0d",
                     $time, want.word, want.status, want.count,
                     got.word, got.status, got.count);
            errors++;
          end
        end
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(20, 70);
        recv_stall = (recv_calm > 0) ? 0 : draw_gap();
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    plan_ops();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (ops_accepted < ops_planned || list_replies_due.size() != 0);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### indexed_list_engine_core.f
+incdir+design
design/ilist_pkg.sv
design/ilist_cell.sv
design/indexed_list_engine_core.sv
design/ilist_checker.sv
tb/tb_indexed_list_engine_core.sv
